// ===== sv/cangw_pkg.sv =====
// shared types and constants of the can gateway frame filter and arbiter
package cangw_pkg;

  localparam int CntW = 32;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_INGRESS = 2'd0;
  localparam cmd_t CMD_EGRESS  = 2'd1;
  localparam cmd_t CMD_CLEAR   = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_PARSE     = 3'd1;
  localparam status_t ST_DISABLED  = 3'd2;
  localparam status_t ST_QFULL     = 3'd3;
  localparam status_t ST_SEND_FAIL = 3'd4;

  localparam logic [1:0] SR_ACCEPTED = 2'd0;
  localparam logic [1:0] SR_QFULL    = 2'd1;

  localparam int FLAG_FD_BIT  = 0;
  localparam int FLAG_EXT_BIT = 2;
  localparam int FLAG_RTR_BIT = 3;
  localparam int FLAG_ERR_BIT = 4;
  localparam logic [7:0] FLAG_UNKNOWN = 8'hE0;

  localparam logic [31:0] STD_ID_MAX      = 32'h0000_07FF;
  localparam logic [31:0] EXT_ID_MAX      = 32'h1FFF_FFFF;
  localparam logic [7:0]  FD_DLC_MAX      = 8'd15;
  localparam logic [7:0]  CLASSIC_DLC_MAX = 8'd8;

  localparam int READY_BITS = 4;

  typedef struct packed {
    logic [CntW-1:0] rx;
    logic [CntW-1:0] tx;
    logic [CntW-1:0] drop;
    logic [CntW-1:0] parse;
    logic [CntW-1:0] disabled;
    logic [CntW-1:0] qfull;
  } cnt_t;

  typedef struct packed {
    logic       found;
    logic [1:0] tx_channel;
  } pick_t;

endpackage

// ===== sv/cangw_if.sv =====
// channel interfaces: ingress commands, results and configuration writes
interface cangw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] channel;
  logic [31:0] can_id;
  logic [7:0] dlc;
  logic [7:0] flags;
  logic [1:0] send_result;
  logic [3:0] ready_mask;

  modport source (output valid, cmd, channel, can_id, dlc, flags, send_result, ready_mask,
                  input ready);
  modport sink (input valid, cmd, channel, can_id, dlc, flags, send_result, ready_mask,
                output ready);
endinterface

interface cangw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [1:0]  tx_channel;
  logic [31:0] rx_count;
  logic [31:0] tx_count;
  logic [31:0] drop_count;
  logic [31:0] parse_error_count;
  logic [31:0] disabled_count;
  logic [31:0] queue_full_count;

  modport source (output valid, status, found, tx_channel, rx_count, tx_count, drop_count,
                  parse_error_count, disabled_count, queue_full_count, input ready);
  modport sink (input valid, status, found, tx_channel, rx_count, tx_count, drop_count,
                parse_error_count, disabled_count, queue_full_count, output ready);
endinterface

interface cangw_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] active_mask;

  modport source (output valid, active_mask, input ready);
  modport sink (input valid, active_mask, output ready);
endinterface

// ===== sv/can_gateway_frame_filter_arbiter.sv =====
// top level: can frame filter, round-robin egress arbiter and event counters
// throughput: one command per cycle, held only by back-pressure on the result side
// an input register and a result register frame the check and pick logic
// reset clears the channel enables, the round-robin pointer and all six counters
module can_gateway_frame_filter_arbiter #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  cangw_in_if.sink    in_ch,
  cangw_out_if.source out_ch,
  cangw_cfg_if.sink   cfg_ch
);

  localparam int PTR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MASK_N = (NUM_CHANNELS < 4) ? NUM_CHANNELS : 4;
  localparam logic [3:0] CH_MASK = 4'((1 << MASK_N) - 1);

  logic [3:0]         mask_r;
  logic [PTR_W-1:0]   ptr_r;
  logic [PTR_W-1:0]   ptr_nxt;
  logic [PTR_W-1:0]   pick_ptr;
  cangw_pkg::cnt_t    cnt_r;
  cangw_pkg::cnt_t    cnt_nxt;

  logic               s1_vld_r;
  logic [1:0]         s1_cmd_r;
  logic [7:0]         s1_channel_r;
  logic [31:0]        s1_can_id_r;
  logic [7:0]         s1_dlc_r;
  logic [7:0]         s1_flags_r;
  logic [1:0]         s1_sr_r;
  logic [3:0]         s1_ready_r;

  logic               out_vld_r;
  cangw_pkg::status_t status_r;
  cangw_pkg::status_t status_nxt;
  cangw_pkg::status_t ing_status;
  cangw_pkg::pick_t   pick;
  cangw_pkg::pick_t   pick_r;
  cangw_pkg::pick_t   pick_nxt;

  logic               adv;
  logic               in_take;

  assign adv     = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !s1_vld_r || adv;
  assign cfg_ch.ready = 1'b1;

  cangw_frame_check #(.NUM_CHANNELS(NUM_CHANNELS)) u_check (
    .channel     (s1_channel_r),
    .can_id      (s1_can_id_r),
    .dlc         (s1_dlc_r),
    .flags       (s1_flags_r),
    .send_result (s1_sr_r),
    .active_mask (mask_r),
    .status      (ing_status)
  );

  cangw_rr_pick #(.NUM_CHANNELS(NUM_CHANNELS), .PTR_W(PTR_W)) u_pick (
    .ready_mask (s1_ready_r),
    .ptr        (ptr_r),
    .pick       (pick),
    .ptr_nxt    (pick_ptr)
  );

  always_comb begin
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    status_nxt = cangw_pkg::ST_OK;
    pick_nxt   = '0;
    unique case (s1_cmd_r)
      cangw_pkg::CMD_INGRESS: begin
        status_nxt = ing_status;
        case (ing_status)
          cangw_pkg::ST_PARSE: begin
            cnt_nxt.parse = cnt_r.parse + 32'd1;
            cnt_nxt.drop  = cnt_r.drop + 32'd1;
          end
          cangw_pkg::ST_DISABLED: begin
            cnt_nxt.rx       = cnt_r.rx + 32'd1;
            cnt_nxt.disabled = cnt_r.disabled + 32'd1;
            cnt_nxt.drop     = cnt_r.drop + 32'd1;
          end
          cangw_pkg::ST_QFULL: begin
            cnt_nxt.rx    = cnt_r.rx + 32'd1;
            cnt_nxt.qfull = cnt_r.qfull + 32'd1;
            cnt_nxt.drop  = cnt_r.drop + 32'd1;
          end
          cangw_pkg::ST_SEND_FAIL: begin
            cnt_nxt.rx   = cnt_r.rx + 32'd1;
            cnt_nxt.drop = cnt_r.drop + 32'd1;
          end
          default: begin
            cnt_nxt.rx = cnt_r.rx + 32'd1;
          end
        endcase
      end
      cangw_pkg::CMD_EGRESS: begin
        pick_nxt = pick;
        ptr_nxt  = pick_ptr;
        if (pick.found) begin
          cnt_nxt.tx = cnt_r.tx + 32'd1;
        end
      end
      cangw_pkg::CMD_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= 4'd0;
      ptr_r     <= '0;
      cnt_r     <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mask_r <= cfg_ch.active_mask & CH_MASK;
      end
      if (in_ch.ready) begin
        s1_vld_r <= in_ch.valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        ptr_r     <= ptr_nxt;
        cnt_r     <= cnt_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r     <= in_ch.cmd;
      s1_channel_r <= in_ch.channel;
      s1_can_id_r  <= in_ch.can_id;
      s1_dlc_r     <= in_ch.dlc;
      s1_flags_r   <= in_ch.flags;
      s1_sr_r      <= in_ch.send_result;
      s1_ready_r   <= in_ch.ready_mask;
    end
    if (adv) begin
      status_r <= status_nxt;
      pick_r   <= pick_nxt;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.status            = status_r;
  assign out_ch.found             = pick_r.found;
  assign out_ch.tx_channel        = pick_r.tx_channel;
  assign out_ch.rx_count          = cnt_r.rx;
  assign out_ch.tx_count          = cnt_r.tx;
  assign out_ch.drop_count        = cnt_r.drop;
  assign out_ch.parse_error_count = cnt_r.parse;
  assign out_ch.disabled_count    = cnt_r.disabled;
  assign out_ch.queue_full_count  = cnt_r.qfull;

endmodule

// ===== sv/cangw_frame_check.sv =====
// ingress frame header validation and send outcome classification
module cangw_frame_check #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic [7:0]           channel,
  input  logic [31:0]          can_id,
  input  logic [7:0]           dlc,
  input  logic [7:0]           flags,
  input  logic [1:0]           send_result,
  input  logic [3:0]           active_mask,
  output cangw_pkg::status_t   status
);

  logic is_fd;
  logic is_ext;
  logic bad;
  logic ch_on;

  always_comb begin
    is_fd  = flags[cangw_pkg::FLAG_FD_BIT];
    is_ext = flags[cangw_pkg::FLAG_EXT_BIT];
    bad = ({24'd0, channel} >= 32'(NUM_CHANNELS))
       || (dlc > cangw_pkg::FD_DLC_MAX)
       || ((flags & cangw_pkg::FLAG_UNKNOWN) != 8'd0)
       || flags[cangw_pkg::FLAG_ERR_BIT]
       || (!is_ext && (can_id > cangw_pkg::STD_ID_MAX))
       || (is_ext && (can_id > cangw_pkg::EXT_ID_MAX))
       || (!is_fd && (dlc > cangw_pkg::CLASSIC_DLC_MAX))
       || (is_fd && flags[cangw_pkg::FLAG_RTR_BIT]);
    // channels past the mask width are never enabled
    ch_on = (channel[7:2] == 6'd0) && active_mask[channel[1:0]];

    if (bad) begin
      status = cangw_pkg::ST_PARSE;
    end else if (!ch_on) begin
      status = cangw_pkg::ST_DISABLED;
    end else if (send_result == cangw_pkg::SR_QFULL) begin
      status = cangw_pkg::ST_QFULL;
    end else if (send_result != cangw_pkg::SR_ACCEPTED) begin
      status = cangw_pkg::ST_SEND_FAIL;
    end else begin
      status = cangw_pkg::ST_OK;
    end
  end

endmodule

// ===== sv/cangw_rr_pick.sv =====
// round-robin pick of the first ready channel at or after the pointer
module cangw_rr_pick #(
  parameter int NUM_CHANNELS = 4,
  parameter int PTR_W        = 2
) (
  input  logic [3:0]        ready_mask,
  input  logic [PTR_W-1:0]  ptr,
  output cangw_pkg::pick_t  pick,
  output logic [PTR_W-1:0]  ptr_nxt
);

  logic [cangw_pkg::READY_BITS-1:0] elig;
  logic [cangw_pkg::READY_BITS-1:0] upper;
  logic                             any_upper;
  logic [1:0]                       sel;
  logic [31:0]                      inc;

  always_comb begin
    for (int c = 0; c < cangw_pkg::READY_BITS; c++) begin
      elig[c]  = ready_mask[c] && (c < NUM_CHANNELS);
      upper[c] = elig[c] && (32'(c) >= 32'(ptr));
    end
    any_upper = |upper;
    sel = 2'd0;
    for (int c = cangw_pkg::READY_BITS - 1; c >= 0; c--) begin
      if (any_upper ? upper[c] : elig[c]) begin
        sel = 2'(c);
      end
    end
    pick.found      = |elig;
    pick.tx_channel = pick.found ? sel : 2'd0;
    inc = 32'(sel) + 32'd1;
    if (!pick.found) begin
      ptr_nxt = ptr;
    end else if (inc == 32'(NUM_CHANNELS)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = PTR_W'(inc);
    end
  end

endmodule

// ===== sim/can_gateway_frame_filter_arbiter_tb.sv =====
// testbench for the can gateway frame filter and arbiter: directed and random frames, polls and mask writes
localparam int GwChannels = 4;

localparam cangw_pkg::cmd_t CMD_UNUSED = 2'd3;
localparam logic [1:0] SR_OTHER = 2'd2;
localparam logic [1:0] SR_SPARE = 2'd3;

localparam logic [7:0] FL_FD  = 8'(1) << cangw_pkg::FLAG_FD_BIT;
localparam logic [7:0] FL_BRS = 8'h02;
localparam logic [7:0] FL_EXT = 8'(1) << cangw_pkg::FLAG_EXT_BIT;
localparam logic [7:0] FL_RTR = 8'(1) << cangw_pkg::FLAG_RTR_BIT;
localparam logic [7:0] FL_ERR = 8'(1) << cangw_pkg::FLAG_ERR_BIT;

typedef struct packed {
  cangw_pkg::cmd_t cmd;
  logic [7:0]      channel;
  logic [31:0]     can_id;
  logic [7:0]      dlc;
  logic [7:0]      flags;
  logic [1:0]      send_result;
  logic [3:0]      ready_mask;
} gw_cmd_t;

typedef struct packed {
  cangw_pkg::status_t status;
  logic               found;
  logic [1:0]         tx_channel;
  cangw_pkg::cnt_t    counts;
} gw_result_t;

class gw_event_ledger;
  logic [3:0] enables;
  logic [1:0] rr_ptr;
  cangw_pkg::cnt_t counts;
  gw_result_t awaited_results[$];
  int mismatches;
  int n_status[5];
  int polls;
  int picks;
  int clears;
  int mask_writes;

  function new();
    enables = '0;
    rr_ptr = '0;
    counts = '0;
    mismatches = 0;
    polls = 0;
    picks = 0;
    clears = 0;
    mask_writes = 0;
    foreach (n_status[i]) n_status[i] = 0;
  endfunction

  function void set_enables(logic [3:0] m);
    enables = m & 4'((1 << GwChannels) - 1);
    mask_writes++;
  endfunction

  function bit frame_passes(gw_cmd_t c);
    logic ext;
    logic fd;
    ext = c.flags[cangw_pkg::FLAG_EXT_BIT];
    fd = c.flags[cangw_pkg::FLAG_FD_BIT];
    if (c.channel >= GwChannels || c.dlc > cangw_pkg::FD_DLC_MAX) return 1'b0;
    if ((c.flags & cangw_pkg::FLAG_UNKNOWN) != 0 || c.flags[cangw_pkg::FLAG_ERR_BIT])
      return 1'b0;
    if (!ext && c.can_id > cangw_pkg::STD_ID_MAX) return 1'b0;
    if (ext && c.can_id > cangw_pkg::EXT_ID_MAX) return 1'b0;
    if (!fd && c.dlc > cangw_pkg::CLASSIC_DLC_MAX) return 1'b0;
    if (fd && c.flags[cangw_pkg::FLAG_RTR_BIT]) return 1'b0;
    return 1'b1;
  endfunction

  function void note_command(gw_cmd_t c);
    gw_result_t r;
    logic [3:0] ready;
    int ch;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (c.cmd)
      cangw_pkg::CMD_INGRESS: begin
        if (!frame_passes(c)) begin
          counts.parse += 1;
          counts.drop += 1;
          r.status = cangw_pkg::ST_PARSE;
        end else begin
          counts.rx += 1;
          if (!enables[c.channel[1:0]]) begin
            counts.disabled += 1;
            counts.drop += 1;
            r.status = cangw_pkg::ST_DISABLED;
          end else if (c.send_result == cangw_pkg::SR_QFULL) begin
            counts.qfull += 1;
            counts.drop += 1;
            r.status = cangw_pkg::ST_QFULL;
          end else if (c.send_result != cangw_pkg::SR_ACCEPTED) begin
            counts.drop += 1;
            r.status = cangw_pkg::ST_SEND_FAIL;
          end
        end
        n_status[r.status]++;
      end
      cangw_pkg::CMD_EGRESS: begin
        polls++;
        ready = c.ready_mask & 4'((1 << GwChannels) - 1);
        for (int off = 0; off < GwChannels; off++) begin
          ch = (int'(rr_ptr) + off) % GwChannels;
          if (!hit && ch < cangw_pkg::READY_BITS && ready[ch]) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.tx_channel = 2'(ch);
            rr_ptr = 2'((ch + 1) % GwChannels);
            counts.tx += 1;
            picks++;
          end
        end
      end
      cangw_pkg::CMD_CLEAR: begin
        counts = '0;
        clears++;
      end
      default: ;
    endcase
    r.counts = counts;
    awaited_results.push_back(r);
  endfunction

  task report(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40) $display("mismatch on %s: got %0h, expected %0h", field, got, want);
  endtask

  task check_result(gw_result_t got);
    gw_result_t want;
    if (awaited_results.size() == 0) begin
      report("result with no transaction awaiting it", 32'(got.status), 0);
      return;
    end
    want = awaited_results.pop_front();
    if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
    if (got.found !== want.found) report("found", 32'(got.found), 32'(want.found));
    if (got.tx_channel !== want.tx_channel)
      report("tx_channel", 32'(got.tx_channel), 32'(want.tx_channel));
    if (got.counts.rx !== want.counts.rx) report("rx_count", got.counts.rx, want.counts.rx);
    if (got.counts.tx !== want.counts.tx) report("tx_count", got.counts.tx, want.counts.tx);
    if (got.counts.drop !== want.counts.drop)
      report("drop_count", got.counts.drop, want.counts.drop);
    if (got.counts.parse !== want.counts.parse)
      report("parse_error_count", got.counts.parse, want.counts.parse);
    if (got.counts.disabled !== want.counts.disabled)
      report("disabled_count", got.counts.disabled, want.counts.disabled);
    if (got.counts.qfull !== want.counts.qfull)
      report("queue_full_count", got.counts.qfull, want.counts.qfull);
  endtask

  function int pending();
    return awaited_results.size();
  endfunction
endclass

module can_gateway_frame_filter_arbiter_tb;
  localparam int IdleLimit = 5000;
  localparam int PhaseItems = 200;

  logic clk = 1'b0;
  logic rst_n;
  int idle_count = 0;
  int sink_cycle = 0;
  int stall_style = 0;
  gw_event_ledger ledger;

  cangw_in_if  in_ch();
  cangw_out_if out_ch();
  cangw_cfg_if cfg_ch();

  can_gateway_frame_filter_arbiter #(
    .NUM_CHANNELS(GwChannels)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1;
    if (sink_cycle % 96 == 0) stall_style <= $urandom_range(0, 2);
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= (sink_cycle % 7) < 4;
    endcase
  end

  always @(posedge clk) begin
    gw_result_t got;
    gw_cmd_t taken;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) ledger.set_enables(cfg_ch.active_mask);
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.found = out_ch.found;
        got.tx_channel = out_ch.tx_channel;
        got.counts.rx = out_ch.rx_count;
        got.counts.tx = out_ch.tx_count;
        got.counts.drop = out_ch.drop_count;
        got.counts.parse = out_ch.parse_error_count;
        got.counts.disabled = out_ch.disabled_count;
        got.counts.qfull = out_ch.queue_full_count;
        ledger.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.cmd = in_ch.cmd;
        taken.channel = in_ch.channel;
        taken.can_id = in_ch.can_id;
        taken.dlc = in_ch.dlc;
        taken.flags = in_ch.flags;
        taken.send_result = in_ch.send_result;
        taken.ready_mask = in_ch.ready_mask;
        ledger.note_command(taken);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_count <= 0;
    end else if (idle_count == IdleLimit) begin
      $display("can_gateway_frame_filter_arbiter_tb failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task put_payload(gw_cmd_t c);
    in_ch.cmd <= c.cmd;
    in_ch.channel <= c.channel;
    in_ch.can_id <= c.can_id;
    in_ch.dlc <= c.dlc;
    in_ch.flags <= c.flags;
    in_ch.send_result <= c.send_result;
    in_ch.ready_mask <= c.ready_mask;
  endtask

  task send_item(gw_cmd_t c);
    in_ch.valid <= 1'b1;
    put_payload(c);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function gw_cmd_t random_cmd();
    gw_cmd_t c;
    int pick;
    logic ext;
    logic fd;
    c = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 60) c.cmd = cangw_pkg::CMD_INGRESS;
    else if (pick < 95) c.cmd = cangw_pkg::CMD_EGRESS;
    else if (pick < 97) c.cmd = cangw_pkg::CMD_CLEAR;
    else c.cmd = CMD_UNUSED;
    if (c.cmd == cangw_pkg::CMD_INGRESS && $urandom_range(0, 4) != 0) begin
      ext = 1'($urandom);
      fd = 1'($urandom);
      c.channel = 8'($urandom_range(0, GwChannels - 1));
      c.flags = '0;
      c.flags[cangw_pkg::FLAG_FD_BIT] = fd;
      c.flags[cangw_pkg::FLAG_EXT_BIT] = ext;
      if ($urandom_range(0, 1) == 0) c.flags = c.flags | FL_BRS;
      if (!fd && $urandom_range(0, 3) == 0) c.flags = c.flags | FL_RTR;
      c.dlc = 8'($urandom_range(0, fd ? 15 : 8));
      c.can_id = ext ? ($urandom & cangw_pkg::EXT_ID_MAX) : ($urandom & cangw_pkg::STD_ID_MAX);
      if ($urandom_range(0, 7) == 0)
        c.can_id = ext ? cangw_pkg::EXT_ID_MAX : cangw_pkg::STD_ID_MAX;
      c.send_result = ($urandom_range(0, 2) == 0) ? 2'($urandom) : cangw_pkg::SR_ACCEPTED;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0: c.channel = 8'($urandom_range(GwChannels, 255));
          1: c.dlc = 8'($urandom_range(16, 255));
          2: c.flags[$urandom_range(5, 7)] = 1'b1;
          3: c.flags = c.flags | FL_ERR;
          4: c.can_id = $urandom_range(cangw_pkg::EXT_ID_MAX + 1, 32'hFFFF_FFFF);
          5: c.can_id = ext ? $urandom_range(cangw_pkg::EXT_ID_MAX + 1, 32'hFFFF_FFFF)
                            : $urandom_range(cangw_pkg::STD_ID_MAX + 1, 32'hFFFF_FFFF);
          6: begin
            c.flags[cangw_pkg::FLAG_FD_BIT] = 1'b0;
            c.dlc = 8'($urandom_range(9, 15));
          end
          default: c.flags = c.flags | FL_FD | FL_RTR;
        endcase
      end
    end
    return c;
  endfunction

  function gw_cmd_t frame(logic [7:0] ch, logic [31:0] id, logic [7:0] dlc,
                          logic [7:0] flags, logic [1:0] sr);
    gw_cmd_t c;
    c = {$urandom, $urandom};
    c.cmd = cangw_pkg::CMD_INGRESS;
    c.channel = ch;
    c.can_id = id;
    c.dlc = dlc;
    c.flags = flags;
    c.send_result = sr;
    return c;
  endfunction

  function gw_cmd_t poll(logic [3:0] ready);
    gw_cmd_t c;
    c = {$urandom, $urandom};
    c.cmd = cangw_pkg::CMD_EGRESS;
    c.ready_mask = ready;
    return c;
  endfunction

  function gw_cmd_t op(cangw_pkg::cmd_t code);
    gw_cmd_t c;
    c = {$urandom, $urandom};
    c.cmd = code;
    return c;
  endfunction

  task go_idle(int n);
    in_ch.valid <= 1'b0;
    repeat (n) begin
      put_payload(random_cmd());
      @(posedge clk);
    end
  endtask

  task wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task write_mask(logic [3:0] m);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.active_mask <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task run_directed();
    send_item(frame(0, 0, 0, 0, cangw_pkg::SR_ACCEPTED));
    send_item(frame(3, cangw_pkg::STD_ID_MAX, cangw_pkg::CLASSIC_DLC_MAX, 0,
                    cangw_pkg::SR_ACCEPTED));
    send_item(frame(1, cangw_pkg::STD_ID_MAX + 1, 0, 0, cangw_pkg::SR_ACCEPTED));
    send_item(frame(0, cangw_pkg::EXT_ID_MAX, cangw_pkg::FD_DLC_MAX, FL_EXT | FL_FD | FL_BRS,
                    cangw_pkg::SR_ACCEPTED));
    send_item(frame(0, cangw_pkg::EXT_ID_MAX + 1, 0, FL_EXT, cangw_pkg::SR_ACCEPTED));
    send_item(frame(4, 0, 0, 0, cangw_pkg::SR_ACCEPTED));
    send_item(frame(8'hFF, 0, 0, 0, cangw_pkg::SR_ACCEPTED));
    send_item(frame(0, 0, 8'(cangw_pkg::FD_DLC_MAX + 8'd1), FL_FD, cangw_pkg::SR_ACCEPTED));
    send_item(frame(0, 0, 8'(cangw_pkg::CLASSIC_DLC_MAX + 8'd1), 0, cangw_pkg::SR_ACCEPTED));
    send_item(frame(0, 0, 0, cangw_pkg::FLAG_UNKNOWN, cangw_pkg::SR_ACCEPTED));
    send_item(frame(0, 0, 0, FL_ERR, cangw_pkg::SR_ACCEPTED));
    send_item(frame(0, 0, 0, FL_FD | FL_RTR, cangw_pkg::SR_ACCEPTED));
    send_item(frame(1, 32'h123, 0, FL_RTR, cangw_pkg::SR_ACCEPTED));
    send_item(frame(2, 0, 0, 0, cangw_pkg::SR_ACCEPTED));
    send_item(frame(1, 0, 1, 0, cangw_pkg::SR_QFULL));
    send_item(frame(1, 0, 1, 0, SR_OTHER));
    send_item(frame(1, 0, 1, 0, SR_SPARE));
    send_item(poll(4'h0));
    send_item(poll(4'hF));
    send_item(poll(4'b0001));
    send_item(op(CMD_UNUSED));
    send_item(op(cangw_pkg::CMD_CLEAR));
    send_item(poll(4'b1100));
    send_item(frame(0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, SR_SPARE));
  endtask

  task run_random(int n);
    int sent;
    int burst;
    int gap;
    int hold_at;
    sent = 0;
    hold_at = $urandom_range(1, n - 1);
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_item(random_cmd());
        sent++;
        if (sent == hold_at) wait_drained();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) go_idle(gap);
    end
  endtask

  initial begin
    ledger = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    put_payload('0);
    cfg_ch.valid <= 1'b0;
    cfg_ch.active_mask <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mask(4'b1011);
    run_directed();
    for (int p = 0; p < 8; p++) begin
      write_mask((p == 0) ? 4'hF : (p == 1) ? 4'h0 : 4'($urandom_range(0, 15)));
      run_random(PhaseItems);
    end
    wait_drained();
    repeat (8) @(posedge clk);
    $display("frames: %0d ok, %0d malformed, %0d to disabled channels, %0d queue full,",
             ledger.n_status[cangw_pkg::ST_OK], ledger.n_status[cangw_pkg::ST_PARSE],
             ledger.n_status[cangw_pkg::ST_DISABLED], ledger.n_status[cangw_pkg::ST_QFULL]);
    $display("%0d send errors; egress polls: %0d with %0d picks; %0d clears; %0d mask writes",
             ledger.n_status[cangw_pkg::ST_SEND_FAIL], ledger.polls, ledger.picks,
             ledger.clears, ledger.mask_writes);
    if (ledger.mismatches == 0) begin
      $display("can_gateway_frame_filter_arbiter_tb passed");
    end else begin
      $display("can_gateway_frame_filter_arbiter_tb failed");
    end
    $finish;
  end
endmodule
